// ----- hdl/ffha_pkg.sv -----
// Shared constants for the first-fit heap allocator.
package ffha_pkg;
  localparam int ADDR_W  = 16;
  localparam int COUNT_W = 17;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
endpackage

// ----- hdl/first_fit_heap_allocator.sv -----
// Top level: first-fit free-list heap allocator with address-ordered coalescing.
// Allocate divides, walks the free list first-fit and writes the block header; a split block
//   then inserts its remainder by an address-ordered walk. Free divides, checks the header, inserts.
//   Rejects: zero size or short free in idle, early reject after the divide, bad header in the check.
// Requests: one at a time; in_ready rises when the result loads, and the next transfer follows it.
// Reset (rst_n, synchronous): a clearing pass writes all HEAP_BYTES/ALIGN_BYTES headers, one per
//   cycle, before the first request is taken.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES  = 65536,
  parameter int ALIGN_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [ffha_pkg::ADDR_W-1:0]   in_request_bytes,
  input  logic [ffha_pkg::ADDR_W-1:0]   in_block_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [ffha_pkg::ADDR_W-1:0]   out_payload_address,
  output logic [ffha_pkg::COUNT_W-1:0]  out_free_bytes,
  output logic [ffha_pkg::COUNT_W-1:0]  out_min_free_bytes
);
  import ffha_pkg::*;

  // Geometry; sizes and counts are kept in granules internally.
  localparam int HDR_BYTES   = ((8 + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int HDR_G       = HDR_BYTES / ALIGN_BYTES;
  localparam int MIN_SPLIT_G = 2 * HDR_G;
  localparam int NGRAN       = HEAP_BYTES / ALIGN_BYTES;
  localparam int END_GRAN    = (HEAP_BYTES - HDR_BYTES) / ALIGN_BYTES;
  localparam int GW          = $clog2(NGRAN);
  localparam int DW          = ADDR_W + 1;           // dividend width
  localparam int RW          = $clog2(ALIGN_BYTES) + 1;
  // reciprocal of the granule size, exact for every DW-bit dividend
  localparam int     DIV_SH  = DW + $clog2(ALIGN_BYTES);
  localparam int     PW      = DW + DIV_SH + 1;
  localparam longint RECIP   = ((longint'(1) << DIV_SH) + ALIGN_BYTES - 1) / ALIGN_BYTES;

  typedef struct packed {
    logic [GW-1:0] size;
    logic [GW-1:0] next;
    logic          alloc;
    logic          linked;
  } hdr_t;

  typedef enum logic [10:0] {
    S_CLR      = 11'b00000000001,
    S_IDLE     = 11'b00000000010,
    S_DIV      = 11'b00000000100,
    S_POST     = 11'b00000001000,
    S_A_CHK    = 11'b00000010000,
    S_A_BLK    = 11'b00000100000,
    S_F_CHK    = 11'b00001000000,
    S_PB_START = 11'b00010000000,
    S_PB_CHK   = 11'b00100000000,
    S_PB_W2    = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_t;

  localparam logic [GW-1:0] END_G = GW'(END_GRAN);

  // Header memory: one write and one registered read per cycle.
  hdr_t          mem [NGRAN];
  hdr_t          rdata_r;
  logic          we;
  logic [GW-1:0] waddr;
  logic [GW-1:0] raddr;
  hdr_t          wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  state_t        state_r, state_nxt;
  logic [GW-1:0] clr_r, clr_nxt;
  logic          op_r, op_nxt;
  logic [DW-1:0] d_r, d_nxt;            // dividend, then quotient
  logic [RW-1:0] r_r, r_nxt;            // remainder
  logic [DW-1:0] want_r, want_nxt;      // request in granules
  logic [GW-1:0] blk_r, blk_nxt;
  logic [GW-1:0] prev_r, prev_nxt;
  hdr_t          prev_h_r, prev_h_nxt;
  logic          prev_head_r, prev_head_nxt;
  logic [GW-1:0] blksz_r, blksz_nxt;
  logic          split_r, split_nxt;
  logic [GW-1:0] b_r, b_nxt;            // block being inserted
  hdr_t          b_h_r, b_h_nxt;
  logic [GW-1:0] it_r, it_nxt;
  hdr_t          it_h_r, it_h_nxt;
  logic          at_head_r, at_head_nxt;
  logic [GW-1:0] nxt_r, nxt_nxt;
  hdr_t          it_new_r, it_new_nxt;
  logic          it_wr_r, it_wr_nxt;
  logic [GW-1:0] head_r, head_nxt;
  logic [GW-1:0] free_r, free_nxt;
  logic [GW-1:0] low_r, low_nxt;
  logic          fail_r, fail_nxt;
  logic [ADDR_W-1:0] pay_r, pay_nxt;
  logic          ov_r, ov_nxt;
  logic          os_r, os_nxt;
  logic [ADDR_W-1:0]  opay_r, opay_nxt;
  logic [COUNT_W-1:0] ofree_r, ofree_nxt;
  logic [COUNT_W-1:0] omin_r, omin_nxt;

  logic [PW-1:0] prod;
  logic [DW-1:0] quo;
  logic [DW-1:0] quo_x;
  hdr_t          h;
  hdr_t          bn;
  logic [GW-1:0] rem;
  logic [GW-1:0] fsub;

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = ov_r;
  assign out_status          = os_r;
  assign out_payload_address = opay_r;
  assign out_free_bytes      = ofree_r;
  assign out_min_free_bytes  = omin_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    d_nxt         = d_r;
    r_nxt         = r_r;
    want_nxt      = want_r;
    blk_nxt       = blk_r;
    prev_nxt      = prev_r;
    prev_h_nxt    = prev_h_r;
    prev_head_nxt = prev_head_r;
    blksz_nxt     = blksz_r;
    split_nxt     = split_r;
    b_nxt         = b_r;
    b_h_nxt       = b_h_r;
    it_nxt        = it_r;
    it_h_nxt      = it_h_r;
    at_head_nxt   = at_head_r;
    nxt_nxt       = nxt_r;
    it_new_nxt    = it_new_r;
    it_wr_nxt     = it_wr_r;
    head_nxt      = head_r;
    free_nxt      = free_r;
    low_nxt       = low_r;
    fail_nxt      = fail_r;
    pay_nxt       = pay_r;
    ov_nxt        = ov_r & ~out_ready;
    os_nxt        = os_r;
    opay_nxt      = opay_r;
    ofree_nxt     = ofree_r;
    omin_nxt      = omin_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    raddr         = '0;
    h             = rdata_r;
    bn            = '0;
    rem           = '0;
    fsub          = '0;
    prod          = '0;
    quo           = '0;
    quo_x         = '0;

    case (state_r)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_r;
        if (clr_r == '0) begin
          wdata = '{size: END_G, next: END_G, alloc: 1'b0, linked: 1'b1};
        end
        clr_nxt = clr_r + GW'(1);
        if (32'(clr_r) == NGRAN - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_opcode;
          fail_nxt = 1'b0;
          pay_nxt  = '0;
          r_nxt    = '0;
          if (in_opcode == OP_ALLOC) begin
            d_nxt = DW'(in_request_bytes) + DW'(HDR_BYTES);
            if (in_request_bytes == '0) begin
              fail_nxt  = 1'b1;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_DIV;
            end
          end else begin
            d_nxt = DW'(in_block_address) - DW'(HDR_BYTES);
            if (32'(in_block_address) < HDR_BYTES) begin
              fail_nxt  = 1'b1;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        // divide by the granule size through a constant reciprocal
        prod      = PW'(d_r) * PW'(RECIP);
        quo       = DW'(prod >> DIV_SH);
        quo_x     = quo * DW'(ALIGN_BYTES);
        r_nxt     = RW'(d_r - quo_x);
        d_nxt     = quo;
        state_nxt = S_POST;
      end
      S_POST: begin
        if (op_r == OP_FREE) begin
          if (r_r != '0 || 32'(d_r) >= NGRAN) begin
            fail_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            b_nxt     = GW'(d_r);
            raddr     = GW'(d_r);
            state_nxt = S_F_CHK;
          end
        end else begin
          want_nxt = d_r + DW'(r_r != '0);
          if (32'(d_r) + 32'(r_r != '0) > 32'(free_r)) begin
            fail_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            blk_nxt       = head_r;
            raddr         = head_r;
            prev_head_nxt = 1'b1;
            state_nxt     = S_A_CHK;
          end
        end
      end
      S_A_CHK: begin
        // first-fit walk, one header per cycle
        if (32'(h.size) < 32'(want_r) && h.linked) begin
          prev_nxt      = blk_r;
          prev_h_nxt    = h;
          prev_head_nxt = 1'b0;
          blk_nxt       = h.next;
          raddr         = h.next;
        end else if (blk_r == END_G || 32'(h.size) < 32'(want_r)) begin
          fail_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          if (prev_head_r) begin
            head_nxt = h.next;
          end else begin
            we    = 1'b1;
            waddr = prev_r;
            wdata = '{size: prev_h_r.size, next: h.next, alloc: prev_h_r.alloc,
                      linked: h.linked};
          end
          rem = h.size - GW'(want_r);
          if (32'(rem) > MIN_SPLIT_G) begin
            split_nxt = 1'b1;
            b_nxt     = blk_r + GW'(want_r);
            b_h_nxt   = '{size: rem, next: '0, alloc: 1'b0, linked: 1'b0};
            blksz_nxt = GW'(want_r);
          end else begin
            split_nxt = 1'b0;
            blksz_nxt = h.size;
          end
          state_nxt = S_A_BLK;
        end
      end
      S_A_BLK: begin
        we       = 1'b1;
        waddr    = blk_r;
        wdata    = '{size: blksz_r, next: '0, alloc: 1'b1, linked: 1'b0};
        fsub     = free_r - blksz_r;
        free_nxt = fsub;
        if (fsub < low_r) begin
          low_nxt = fsub;
        end
        pay_nxt   = ADDR_W'(32'(blk_r) * ALIGN_BYTES + HDR_BYTES);
        // on heaps past 64 KiB the 16-bit offset can wrap to null
        fail_nxt  = (pay_nxt == '0);
        state_nxt = split_r ? S_PB_START : S_DONE;
      end
      S_F_CHK: begin
        if (!h.alloc || h.linked) begin
          fail_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          b_h_nxt   = '{size: h.size, next: h.next, alloc: 1'b0, linked: h.linked};
          free_nxt  = free_r + h.size;
          state_nxt = S_PB_START;
        end
      end
      S_PB_START: begin
        at_head_nxt = 1'b1;
        it_nxt      = '0;
        nxt_nxt     = head_r;
        raddr       = head_r;
        state_nxt   = S_PB_CHK;
      end
      S_PB_CHK: begin
        // address-ordered insert walk; rdata holds the header at nxt
        if (nxt_r < b_r) begin
          it_nxt      = nxt_r;
          it_h_nxt    = h;
          at_head_nxt = 1'b0;
          nxt_nxt     = h.next;
          raddr       = h.next;
        end else begin
          if (({1'b0, b_r} + {1'b0, b_h_r.size}) == {1'b0, nxt_r} && nxt_r != END_G) begin
            bn = '{size: b_h_r.size + h.size, next: h.next, alloc: b_h_r.alloc,
                   linked: h.linked};
          end else begin
            bn = '{size: b_h_r.size, next: nxt_r, alloc: b_h_r.alloc, linked: 1'b1};
          end
          we    = 1'b1;
          waddr = b_r;
          wdata = bn;
          if (!at_head_r && ({1'b0, it_r} + {1'b0, it_h_r.size}) == {1'b0, b_r}) begin
            it_new_nxt = '{size: it_h_r.size + bn.size, next: bn.next, alloc: it_h_r.alloc,
                           linked: bn.linked};
            it_wr_nxt  = 1'b1;
          end else if (at_head_r) begin
            head_nxt  = b_r;
            it_wr_nxt = 1'b0;
          end else begin
            it_new_nxt = '{size: it_h_r.size, next: b_r, alloc: it_h_r.alloc, linked: 1'b1};
            it_wr_nxt  = 1'b1;
          end
          state_nxt = S_PB_W2;
        end
      end
      S_PB_W2: begin
        if (it_wr_r) begin
          we    = 1'b1;
          waddr = it_r;
          wdata = it_new_r;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          os_nxt    = fail_r;
          opay_nxt  = pay_r;
          ofree_nxt = COUNT_W'(32'(free_r) * ALIGN_BYTES);
          omin_nxt  = COUNT_W'(32'(low_r) * ALIGN_BYTES);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      head_r  <= '0;
      free_r  <= END_G;
      low_r   <= END_G;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      head_r  <= head_nxt;
      free_r  <= free_nxt;
      low_r   <= low_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    d_r         <= d_nxt;
    r_r         <= r_nxt;
    want_r      <= want_nxt;
    blk_r       <= blk_nxt;
    prev_r      <= prev_nxt;
    prev_h_r    <= prev_h_nxt;
    prev_head_r <= prev_head_nxt;
    blksz_r     <= blksz_nxt;
    split_r     <= split_nxt;
    b_r         <= b_nxt;
    b_h_r       <= b_h_nxt;
    it_r        <= it_nxt;
    it_h_r      <= it_h_nxt;
    at_head_r   <= at_head_nxt;
    nxt_r       <= nxt_nxt;
    it_new_r    <= it_new_nxt;
    it_wr_r     <= it_wr_nxt;
    fail_r      <= fail_nxt;
    pay_r       <= pay_nxt;
    os_r        <= os_nxt;
    opay_r      <= opay_nxt;
    ofree_r     <= ofree_nxt;
    omin_r      <= omin_nxt;
  end
endmodule
